// File: sv/sld_pkg.sv
package sld_pkg;

    // Sequencer states, one-hot
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_EXEC = 7'b0000010,
        S_SAVE = 7'b0000100,
        S_LOAD = 7'b0001000,
        S_COPY = 7'b0010000,
        S_FILL = 7'b0100000,
        S_DONE = 7'b1000000
    } sld_state_t;

    // Result handed from the core to the output register
    typedef struct packed {
        logic        valid;
        logic [10:0] frame;
    } sld_res_t;

    localparam logic [10:0] EOT_FRAME = 11'h540;

    // Frame classes (bits 10-8)
    localparam logic [2:0] CLS_CMD = 3'b100;
    localparam logic [2:0] CLS_RDY = 3'b101;

    // Command groups (bits 7-5 of a command)
    localparam logic [2:0] GRP_MISC   = 3'd0;
    localparam logic [2:0] GRP_LISTEN = 3'd1;
    localparam logic [2:0] GRP_TALK   = 3'd2;
    localparam logic [2:0] GRP_IFC    = 3'd4;
    localparam logic [2:0] GRP_LMODE  = 3'd5;
    localparam logic [2:0] GRP_TMODE  = 3'd6;

    localparam logic [7:0] CMD_SDC = 8'd4;
    localparam logic [7:0] CMD_DCL = 8'd20;
    localparam logic [4:0] ADR_UNL = 5'd31;
    localparam logic [4:0] IFC_IFC = 5'd16;
    localparam logic [4:0] IFC_AAU = 5'd26;

    // Listen modes
    localparam logic [4:0] LM_WRITE   = 5'd0;
    localparam logic [4:0] LM_SPARE   = 5'd1;
    localparam logic [4:0] LM_BUF     = 5'd2;
    localparam logic [4:0] LM_PTR     = 5'd3;
    localparam logic [4:0] LM_SEEK    = 5'd4;
    localparam logic [4:0] LM_FORMAT  = 5'd5;
    localparam logic [4:0] LM_PARTIAL = 5'd6;
    localparam logic [4:0] LM_REWIND  = 5'd7;
    localparam logic [4:0] LM_FLUSH   = 5'd8;
    localparam logic [4:0] LM_COPY    = 5'd9;
    localparam logic [4:0] LM_XCHG    = 5'd10;

    // Talk modes
    localparam logic [4:0] TM_READ  = 5'd0;
    localparam logic [4:0] TM_SPARE = 5'd1;
    localparam logic [4:0] TM_NEXT  = 5'd2;
    localparam logic [4:0] TM_POS   = 5'd3;
    localparam logic [4:0] TM_XCHG  = 5'd4;
    localparam logic [4:0] TM_GEOM  = 5'd6;
    localparam logic [4:0] TM_CAP   = 5'd7;
    localparam logic [4:0] TM_DONE  = 5'd15;

    // Ready frame codes
    localparam logic [7:0] RDY_NRE     = 8'd66;
    localparam logic [7:0] RDY_SDA     = 8'd96;
    localparam logic [7:0] RDY_SST     = 8'd97;
    localparam logic [7:0] RDY_SDI     = 8'd98;
    localparam logic [7:0] RDY_SAI     = 8'd99;
    localparam logic [7:0] RDY_AAD_END = 8'h9E;

    // Loop states
    localparam logic [7:0] LS_IDLE      = 8'h00;
    localparam logic [7:0] LS_LISTEN    = 8'h80;
    localparam logic [7:0] LS_TALK      = 8'h40;
    localparam logic [7:0] LS_TALK_BYTE = 8'hC1;
    localparam logic [7:0] LS_TALK_DATA = 8'hC2;
    localparam logic [7:0] LS_TALK_ID   = 8'hC3;
    localparam logic [7:0] LS_SDA_MASK  = 8'hFD;

    localparam logic [7:0] STATUS_MASK     = 8'hE0;
    localparam logic [7:0] STATUS_SEEK_ERR = 8'd28;
    localparam logic [7:0] ACC_ID          = 8'd16;
    localparam logic [7:0] AUTO_ADDR       = 8'd2;
    localparam logic [7:0] CHAR_CR         = 8'h0D;
    localparam logic [7:0] ID_FIRST        = 8'h48;

    // Device ID string, eight characters ending in carriage return
    function automatic logic [7:0] sld_ident(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h48;
            3'd1:    c = 8'h44;
            3'd2:    c = 8'h52;
            3'd3:    c = 8'h49;
            3'd4:    c = 8'h56;
            3'd5:    c = 8'h45;
            3'd6:    c = 8'h31;
            default: c = CHAR_CR;
        endcase
        return c;
    endfunction

    // Geometry report: tracks, heads, sectors per track as 32-bit words
    function automatic logic [7:0] sld_geom(input logic [3:0] idx);
        logic [7:0] g;
        case (idx)
            4'd3:    g = 8'd80;
            4'd7:    g = 8'd2;
            4'd11:   g = 8'd16;
            default: g = 8'd0;
        endcase
        return g;
    endfunction

endpackage

// File: sv/sld_core.sv
module sld_core #(
    parameter int SECTOR_COUNT = 2560
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  logic [10:0]       in_frame,
    output logic              in_ready,
    output sld_pkg::sld_res_t res,
    input  logic              res_take
);
    import sld_pkg::*;

    localparam int SEC_W       = (SECTOR_COUNT > 1) ? $clog2(SECTOR_COUNT) : 1;
    localparam int SA_W        = SEC_W + 8;
    localparam int STORE_DEPTH = SECTOR_COUNT * 256;
    localparam int FC_W        = (SA_W > 9) ? SA_W : 9;
    localparam logic [FC_W-1:0] STORE_LAST = FC_W'(STORE_DEPTH - 1);
    localparam logic [FC_W-1:0] BUF_LAST   = FC_W'(511);
    localparam logic [15:0]     SEC_LIMIT  = 16'(SECTOR_COUNT);
    localparam logic [7:0]      CAP_HI     = 8'(SECTOR_COUNT / 256);
    localparam logic [7:0]      CAP_LO     = 8'(SECTOR_COUNT % 256);

    // Memories: both buffers in one array (bank bit on top), and the sector store
    logic [7:0] buf_mem [512];
    logic [7:0] st_mem  [STORE_DEPTH];

    logic           buf_we;
    logic [8:0]     buf_waddr, buf_raddr;
    logic [7:0]     buf_wdata, buf_rdata;
    logic           st_we;
    logic [SA_W-1:0] st_waddr, st_raddr;
    logic [7:0]     st_wdata, st_rdata;

    // Sequencer and drive registers
    sld_state_t state_reg, state_next;
    logic [10:0] frame_reg, frame_next;
    logic [10:0] res_reg, res_next;
    logic [7:0]  loop_state_reg, loop_state_next;
    logic [7:0]  own_address_reg, own_address_next;
    logic [3:0]  id_pointer_reg, id_pointer_next;
    logic [7:0]  status_byte_reg, status_byte_next;
    logic [4:0]  listen_mode_reg, listen_mode_next;
    logic [4:0]  talk_mode_reg, talk_mode_next;
    logic [7:0]  byte_pointer_reg, byte_pointer_next;
    logic [15:0] sector_pointer_reg, sector_pointer_next;
    logic [15:0] pending_sector_reg, pending_sector_next;
    logic        seek_high_done_reg, seek_high_done_next;
    logic        partial_write_reg, partial_write_next;
    logic [3:0]  report_pointer_reg, report_pointer_next;
    logic        main_sel_reg, main_sel_next;
    logic [8:0]  swp_reg, swp_next;
    logic [FC_W-1:0] fcnt_reg, fcnt_next;
    logic        clr_buf_reg, clr_buf_next;
    logic        load_after_reg, load_after_next;
    logic        inc_save_reg, inc_save_next;
    logic        inc_load_reg, inc_load_next;

    // Talk byte results
    logic [10:0] t_frame;
    logic [7:0]  t_bp;
    logic [4:0]  t_tm;
    logic [3:0]  t_rp;
    logic        t_load, t_eot;
    logic [3:0]  rp_bump;

    logic        go_save, go_load, go_copy, go_fill;
    logic        in_range, fill_done;
    logic [7:0]  sweep_idx, sweep_prev;
    logic [3:0]  id_m1;
    logic [7:0]  id_char;
    logic [15:0] seek_sector;
    logic [7:0]  cmd_n;
    logic [4:0]  cmd_low;

    assign in_range    = sector_pointer_reg < SEC_LIMIT;
    assign fill_done   = (fcnt_reg >= STORE_LAST) && (!clr_buf_reg || fcnt_reg >= BUF_LAST);
    assign sweep_idx   = swp_reg[7:0];
    assign sweep_prev  = swp_reg[7:0] - 8'd1;
    assign id_m1       = id_pointer_reg - 4'd1;
    assign id_char     = sld_ident(id_m1[2:0]);
    assign seek_sector = {pending_sector_reg[15:8], frame_reg[7:0]};
    assign cmd_n       = frame_reg[7:0];
    assign cmd_low     = frame_reg[4:0];
    assign rp_bump     = (report_pointer_reg == 4'd15) ? 4'd15 : report_pointer_reg + 4'd1;

    // Buffer memory: one write, one registered read
    always_ff @(posedge aclk) begin
        if (buf_we) begin
            buf_mem[buf_waddr] <= buf_wdata;
        end
        buf_rdata <= buf_mem[buf_raddr];
    end

    // Sector store: one write, one registered read
    always_ff @(posedge aclk) begin
        if (st_we) begin
            st_mem[st_waddr] <= st_wdata;
        end
        st_rdata <= st_mem[st_raddr];
    end

    // Form the next talker byte from the buffer read launched while idle
    always_comb begin
        t_frame = EOT_FRAME;
        t_bp    = byte_pointer_reg;
        t_tm    = talk_mode_reg;
        t_rp    = report_pointer_reg;
        t_load  = 1'b0;
        case (talk_mode_reg) inside
            TM_READ, TM_NEXT: begin
                t_frame = {3'b000, buf_rdata};
                t_bp    = byte_pointer_reg + 8'd1;
                t_load  = (byte_pointer_reg == 8'hFF);
            end
            TM_SPARE: begin
                t_frame = {3'b000, buf_rdata};
                t_bp    = byte_pointer_reg + 8'd1;
                if (byte_pointer_reg == 8'hFF) begin
                    t_tm = TM_DONE;
                end
            end
            TM_POS: begin
                case (report_pointer_reg)
                    4'd0:    t_frame = {3'b000, sector_pointer_reg[15:8]};
                    4'd1:    t_frame = {3'b000, sector_pointer_reg[7:0]};
                    4'd2:    t_frame = {3'b000, byte_pointer_reg};
                    default: t_frame = EOT_FRAME;
                endcase
                t_rp = rp_bump;
            end
            TM_GEOM: begin
                if (report_pointer_reg < 4'd12) begin
                    t_frame = {3'b000, sld_geom(report_pointer_reg)};
                    t_rp    = rp_bump;
                end
            end
            TM_CAP: begin
                case (report_pointer_reg)
                    4'd0:    t_frame = {3'b000, CAP_HI};
                    4'd1:    t_frame = {3'b000, CAP_LO};
                    default: t_frame = EOT_FRAME;
                endcase
                t_rp = rp_bump;
            end
            default: t_frame = EOT_FRAME;
        endcase
        t_eot = (t_frame == EOT_FRAME);
    end

    // Sequencer: decode one frame, then walk memories when a command needs it
    always_comb begin
        state_next          = state_reg;
        frame_next          = frame_reg;
        res_next            = res_reg;
        loop_state_next     = loop_state_reg;
        own_address_next    = own_address_reg;
        id_pointer_next     = id_pointer_reg;
        status_byte_next    = status_byte_reg;
        listen_mode_next    = listen_mode_reg;
        talk_mode_next      = talk_mode_reg;
        byte_pointer_next   = byte_pointer_reg;
        sector_pointer_next = sector_pointer_reg;
        pending_sector_next = pending_sector_reg;
        seek_high_done_next = seek_high_done_reg;
        partial_write_next  = partial_write_reg;
        report_pointer_next = report_pointer_reg;
        main_sel_next       = main_sel_reg;
        swp_next            = swp_reg;
        fcnt_next           = fcnt_reg;
        clr_buf_next        = clr_buf_reg;
        load_after_next     = load_after_reg;
        inc_save_next       = inc_save_reg;
        inc_load_next       = inc_load_reg;
        go_save             = 1'b0;
        go_load             = 1'b0;
        go_copy             = 1'b0;
        go_fill             = 1'b0;
        in_ready            = 1'b0;
        res.valid           = 1'b0;
        res.frame           = res_reg;
        buf_we              = 1'b0;
        buf_waddr           = {main_sel_reg, byte_pointer_reg};
        buf_wdata           = frame_reg[7:0];
        buf_raddr           = {main_sel_reg ^ (talk_mode_reg == TM_SPARE), byte_pointer_reg};
        st_we               = 1'b0;
        st_waddr            = {sector_pointer_reg[SEC_W-1:0], sweep_prev};
        st_wdata            = buf_rdata;
        st_raddr            = {sector_pointer_reg[SEC_W-1:0], sweep_idx};

        unique case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    frame_next = in_frame;
                    state_next = S_EXEC;
                end
            end

            S_EXEC: begin
                res_next        = frame_reg;
                state_next      = S_DONE;
                load_after_next = 1'b0;
                inc_save_next   = 1'b0;
                inc_load_next   = 1'b0;
                if (!frame_reg[10]) begin
                    // Data frame
                    if (!loop_state_reg[7]) begin
                        res_next = frame_reg;
                    end else if (!loop_state_reg[6]) begin
                        case (listen_mode_reg) inside
                            LM_WRITE, LM_BUF, LM_PARTIAL: begin
                                buf_we            = 1'b1;
                                byte_pointer_next = byte_pointer_reg + 8'd1;
                                if (byte_pointer_reg == 8'hFF) begin
                                    go_save         = 1'b1;
                                    inc_save_next   = 1'b1;
                                    load_after_next = partial_write_reg;
                                end else if (frame_reg[9]) begin
                                    go_save       = 1'b1;
                                    inc_save_next = !partial_write_reg;
                                end
                            end
                            LM_SPARE: begin
                                buf_we            = 1'b1;
                                buf_waddr         = {~main_sel_reg, byte_pointer_reg};
                                byte_pointer_next = byte_pointer_reg + 8'd1;
                            end
                            LM_PTR: byte_pointer_next = frame_reg[7:0];
                            LM_SEEK: begin
                                if (seek_high_done_reg) begin
                                    pending_sector_next = seek_sector;
                                    if (seek_sector < SEC_LIMIT) begin
                                        sector_pointer_next = seek_sector;
                                        status_byte_next    = 8'd0;
                                    end else begin
                                        status_byte_next = STATUS_SEEK_ERR;
                                    end
                                    seek_high_done_next = 1'b0;
                                end else begin
                                    pending_sector_next = {frame_reg[7:0],
                                                           pending_sector_reg[7:0]};
                                    seek_high_done_next = 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end else if (!loop_state_reg[1]) begin
                        loop_state_next = LS_TALK;
                        res_next        = EOT_FRAME;
                    end else if (!loop_state_reg[0]) begin
                        res_next            = t_frame;
                        byte_pointer_next   = t_bp;
                        talk_mode_next      = t_tm;
                        report_pointer_next = t_rp;
                        go_load             = t_load;
                        inc_load_next       = t_load;
                        if (t_eot) begin
                            loop_state_next = LS_TALK;
                        end
                    end else begin
                        // Device ID characters, then EOT
                        if (id_pointer_reg != 4'd0) begin
                            if (id_char == CHAR_CR) begin
                                id_pointer_next = 4'd0;
                            end else begin
                                id_pointer_next = id_pointer_reg + 4'd1;
                                res_next        = {3'b000, id_char};
                            end
                        end
                        if (id_pointer_reg == 4'd0 || id_char == CHAR_CR) begin
                            res_next        = EOT_FRAME;
                            loop_state_next = LS_TALK;
                        end
                    end
                end else if (frame_reg[10:8] == CLS_CMD) begin
                    unique case (cmd_n[7:5])
                        GRP_MISC: begin
                            if ((cmd_n == CMD_SDC && loop_state_reg[7]) || cmd_n == CMD_DCL) begin
                                seek_high_done_next = 1'b0;
                                sector_pointer_next = 16'd0;
                                byte_pointer_next   = 8'd0;
                            end
                        end
                        GRP_LISTEN: begin
                            if (cmd_low == ADR_UNL) begin
                                if (!loop_state_reg[6]) begin
                                    loop_state_next = LS_IDLE;
                                end
                            end else if (cmd_low == own_address_reg[4:0]) begin
                                loop_state_next = LS_LISTEN;
                            end
                        end
                        GRP_TALK: begin
                            if (cmd_low == own_address_reg[4:0]) begin
                                loop_state_next = LS_TALK;
                            end else if (loop_state_reg[6]) begin
                                loop_state_next = LS_IDLE;
                            end
                        end
                        GRP_IFC: begin
                            if (cmd_low == IFC_IFC) begin
                                loop_state_next = LS_IDLE;
                            end else if (cmd_low == IFC_AAU) begin
                                own_address_next = AUTO_ADDR;
                            end
                        end
                        GRP_LMODE: begin
                            if (loop_state_reg[7:6] == 2'b10) begin
                                listen_mode_next = cmd_low;
                                case (cmd_low)
                                    LM_SPARE: partial_write_next = 1'b0;
                                    LM_BUF: begin
                                        byte_pointer_next  = 8'd0;
                                        partial_write_next = 1'b0;
                                    end
                                    LM_SEEK: begin
                                        partial_write_next  = 1'b0;
                                        seek_high_done_next = 1'b0;
                                    end
                                    LM_FORMAT: begin
                                        status_byte_next = 8'd0;
                                        go_fill          = 1'b1;
                                    end
                                    LM_PARTIAL: begin
                                        partial_write_next = 1'b1;
                                        go_load            = 1'b1;
                                    end
                                    LM_REWIND: begin
                                        seek_high_done_next = 1'b0;
                                        sector_pointer_next = 16'd0;
                                        byte_pointer_next   = 8'd0;
                                    end
                                    LM_FLUSH: begin
                                        go_save       = 1'b1;
                                        inc_save_next = !partial_write_reg;
                                    end
                                    LM_COPY: begin
                                        byte_pointer_next = 8'd0;
                                        go_copy           = 1'b1;
                                    end
                                    LM_XCHG: begin
                                        byte_pointer_next = 8'd0;
                                        main_sel_next     = ~main_sel_reg;
                                    end
                                    default: ;
                                endcase
                            end
                        end
                        GRP_TMODE: begin
                            if (loop_state_reg[6]) begin
                                talk_mode_next      = cmd_low;
                                report_pointer_next = 4'd0;
                                case (cmd_low)
                                    TM_READ: partial_write_next = 1'b0;
                                    TM_NEXT: begin
                                        go_load            = 1'b1;
                                        inc_load_next      = 1'b1;
                                        byte_pointer_next  = 8'd0;
                                        partial_write_next = 1'b0;
                                    end
                                    TM_XCHG: begin
                                        byte_pointer_next = 8'd0;
                                        main_sel_next     = ~main_sel_reg;
                                    end
                                    default: ;
                                endcase
                            end
                        end
                        default: ;
                    endcase
                end else if (frame_reg[10:8] == CLS_RDY) begin
                    if (!cmd_n[7]) begin
                        if (loop_state_reg[6]) begin
                            unique case (cmd_n)
                                RDY_NRE: loop_state_next = loop_state_reg & LS_SDA_MASK;
                                RDY_SDA: begin
                                    res_next            = t_frame;
                                    byte_pointer_next   = t_bp;
                                    talk_mode_next      = t_tm;
                                    report_pointer_next = t_rp;
                                    go_load             = t_load;
                                    inc_load_next       = t_load;
                                    loop_state_next     = t_eot ? LS_TALK : LS_TALK_DATA;
                                end
                                RDY_SST: begin
                                    res_next         = {3'b000, status_byte_reg};
                                    status_byte_next = status_byte_reg & STATUS_MASK;
                                    loop_state_next  = LS_TALK_BYTE;
                                end
                                RDY_SDI: begin
                                    res_next        = {3'b000, ID_FIRST};
                                    id_pointer_next = 4'd2;
                                    loop_state_next = LS_TALK_ID;
                                end
                                RDY_SAI: begin
                                    res_next        = {3'b000, ACC_ID};
                                    loop_state_next = LS_TALK_BYTE;
                                end
                                default: ;
                            endcase
                        end
                    end else if (cmd_n < RDY_AAD_END) begin
                        if (!own_address_reg[7]) begin
                            own_address_next = cmd_n;
                            res_next         = frame_reg + 11'd1;
                        end
                    end
                end
                // Pick the memory walk, if any
                if (go_fill) begin
                    state_next = S_FILL;
                end else if (go_copy) begin
                    state_next = S_COPY;
                end else if (go_save) begin
                    state_next = S_SAVE;
                end else if (go_load) begin
                    state_next = S_LOAD;
                end
            end

            S_SAVE: begin
                // Copy main buffer into the store, one byte a cycle, if the sector is in range
                buf_raddr = {main_sel_reg, sweep_idx};
                if (in_range && swp_reg != 9'd0) begin
                    st_we = 1'b1;
                end
                if (!in_range || swp_reg[8]) begin
                    swp_next = 9'd0;
                    if (inc_save_reg) begin
                        sector_pointer_next = sector_pointer_reg + 16'd1;
                    end
                    state_next = load_after_reg ? S_LOAD : S_DONE;
                end else begin
                    swp_next = swp_reg + 9'd1;
                end
            end

            S_LOAD: begin
                // Copy the current sector into the main buffer, or 0xFF if it is out of range
                if (swp_reg != 9'd0) begin
                    buf_we    = 1'b1;
                    buf_waddr = {main_sel_reg, sweep_prev};
                    buf_wdata = in_range ? st_rdata : 8'hFF;
                end
                if (swp_reg[8]) begin
                    swp_next = 9'd0;
                    if (inc_load_reg) begin
                        sector_pointer_next = sector_pointer_reg + 16'd1;
                    end
                    state_next = S_DONE;
                end else begin
                    swp_next = swp_reg + 9'd1;
                end
            end

            S_COPY: begin
                // Copy main buffer into spare buffer
                buf_raddr = {main_sel_reg, sweep_idx};
                if (swp_reg != 9'd0) begin
                    buf_we    = 1'b1;
                    buf_waddr = {~main_sel_reg, sweep_prev};
                    buf_wdata = buf_rdata;
                end
                if (swp_reg[8]) begin
                    swp_next   = 9'd0;
                    state_next = S_DONE;
                end else begin
                    swp_next = swp_reg + 9'd1;
                end
            end

            S_FILL: begin
                // Erase the store, and after reset the buffers as well
                st_we     = (fcnt_reg <= STORE_LAST);
                st_waddr  = fcnt_reg[SA_W-1:0];
                st_wdata  = 8'hFF;
                buf_we    = clr_buf_reg && (fcnt_reg <= BUF_LAST);
                buf_waddr = fcnt_reg[8:0];
                buf_wdata = 8'h00;
                if (fill_done) begin
                    fcnt_next    = '0;
                    clr_buf_next = 1'b0;
                    state_next   = clr_buf_reg ? S_IDLE : S_DONE;
                end else begin
                    fcnt_next = fcnt_reg + FC_W'(1);
                end
            end

            S_DONE: begin
                res.valid = 1'b1;
                if (res_take) begin
                    state_next = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= S_FILL;
            loop_state_reg     <= LS_IDLE;
            own_address_reg    <= 8'd0;
            id_pointer_reg     <= 4'd0;
            status_byte_reg    <= 8'd0;
            listen_mode_reg    <= 5'd0;
            talk_mode_reg      <= 5'd0;
            byte_pointer_reg   <= 8'd0;
            sector_pointer_reg <= 16'd0;
            pending_sector_reg <= 16'd0;
            seek_high_done_reg <= 1'b0;
            partial_write_reg  <= 1'b0;
            report_pointer_reg <= 4'd0;
            main_sel_reg       <= 1'b0;
            swp_reg            <= 9'd0;
            fcnt_reg           <= '0;
            clr_buf_reg        <= 1'b1;
            load_after_reg     <= 1'b0;
            inc_save_reg       <= 1'b0;
            inc_load_reg       <= 1'b0;
        end else begin
            state_reg          <= state_next;
            loop_state_reg     <= loop_state_next;
            own_address_reg    <= own_address_next;
            id_pointer_reg     <= id_pointer_next;
            status_byte_reg    <= status_byte_next;
            listen_mode_reg    <= listen_mode_next;
            talk_mode_reg      <= talk_mode_next;
            byte_pointer_reg   <= byte_pointer_next;
            sector_pointer_reg <= sector_pointer_next;
            pending_sector_reg <= pending_sector_next;
            seek_high_done_reg <= seek_high_done_next;
            partial_write_reg  <= partial_write_next;
            report_pointer_reg <= report_pointer_next;
            main_sel_reg       <= main_sel_next;
            swp_reg            <= swp_next;
            fcnt_reg           <= fcnt_next;
            clr_buf_reg        <= clr_buf_next;
            load_after_reg     <= load_after_next;
            inc_save_reg       <= inc_save_next;
            inc_load_reg       <= inc_load_next;
        end
    end

    // Frame payload registers
    always_ff @(posedge aclk) begin
        frame_reg <= frame_next;
        res_reg   <= res_next;
    end

endmodule

// File: sv/serial_loop_disc_drive.sv
// Mass-storage drive on an 11-bit serial loop.
// Input channel s_valid/s_ready/s_frame_in takes one loop frame per item;
// output channel m_valid/m_ready/m_frame_out returns exactly one frame per item.
// A plain frame is decoded against the buffer read launched while idle, then
// handed off to the output register; m_valid and s_ready both rise with the
// hand-off, so the core takes no new item until the last one is handed off.
// Commands that move a sector (save, load, next-sector read, partial write,
// flush, buffer copy) walk 256 bytes through the registered-read buffer and
// store memories; a save followed by a load walks both in turn.
// Format erases the store one byte a cycle.
// After reset the block clears the store to 0xFF and both buffers to zero, with
// s_ready low; all loop state resets.
// The output register frees the core: a new item is accepted while the last
// result waits on m_ready, and a finished item holds until the register is free.
module serial_loop_disc_drive #(
    parameter int SECTOR_COUNT = 2560
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [10:0] s_frame_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [10:0] m_frame_out
);
    import sld_pkg::*;

    sld_res_t    res;
    logic        res_take;
    logic        m_valid_reg;
    logic [10:0] m_frame_reg;

    // Take a result when the output register is empty or draining
    assign res_take = !m_valid_reg || m_ready;

    sld_core #(
        .SECTOR_COUNT(SECTOR_COUNT)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_frame (s_frame_in),
        .in_ready (s_ready),
        .res      (res),
        .res_take (res_take)
    );

    // Hold the result item until the receiver takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res.valid && res_take) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res.valid && res_take) begin
            m_frame_reg <= res.frame;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_frame_out = m_frame_reg;

endmodule

// File: tb/sv/tb_serial_loop_disc_drive.sv
module tb_serial_loop_disc_drive;
    import sld_pkg::*;

    localparam int SECTORS     = 2560;
    localparam int STORE_BYTES = SECTORS * 256;
    localparam int SA_W        = $clog2(STORE_BYTES);
    localparam logic [15:0] SEC_LIMIT = 16'(SECTORS);
    localparam int RAND_ITEMS  = 1950;
    localparam int IDLE_LIMIT  = 2000000;
    localparam int HOLD_CYCLES = 400;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [10:0] s_frame_in = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [10:0] m_frame_out;

    // Expected output frames, oldest first
    logic [10:0] exp_frames[$];
    int          err_cnt = 0;
    int          n_sent = 0;
    int          burst_left = 0;
    bit          hold_req = 1'b0;
    int          hold_cnt = 0;
    int          stall_phase = 0;
    int          idle_cnt = 0;

    // Drive model state
    logic [7:0]  ls, own_addr, stat, bptr;
    logic [3:0]  id_ptr, rptr;
    logic [4:0]  lmode, tmode;
    logic [15:0] sptr, pend;
    bit          seek_hi, pwrite;
    bit [7:0]    bufm[256];
    bit [7:0]    bufs[256];
    bit [7:0]    sector_mem[STORE_BYTES];
    bit [7:0]    ident_chars[8] = '{8'h48, 8'h44, 8'h52, 8'h49, 8'h56, 8'h45, 8'h31, 8'h0D};
    bit [7:0]    geo_bytes[12] = '{0, 0, 0, 80, 0, 0, 0, 2, 0, 0, 0, 16};

    serial_loop_disc_drive #(.SECTOR_COUNT(SECTORS)) u_top (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_frame_in (s_frame_in),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_frame_out(m_frame_out)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Sector transfers between store and main buffer
    function automatic void fetch_sector();
        for (int i = 0; i < 256; i++)
            bufm[i] = (sptr < SEC_LIMIT) ? sector_mem[{sptr[SA_W-9:0], 8'(i)}] : 8'hFF;
    endfunction

    function automatic void commit_sector();
        if (sptr < SEC_LIMIT)
            for (int i = 0; i < 256; i++) sector_mem[{sptr[SA_W-9:0], 8'(i)}] = bufm[i];
    endfunction

    function automatic void swap_bufs();
        bit [7:0] t;
        bptr = 0;
        for (int i = 0; i < 256; i++) begin
            t = bufs[i];
            bufs[i] = bufm[i];
            bufm[i] = t;
        end
    endfunction

    function automatic void clear_position();
        seek_hi = 0;
        sptr = 0;
        bptr = 0;
    endfunction

    function automatic void next_report();
        if (rptr < 15) rptr++;
    endfunction

    function automatic logic [10:0] talker_byte();
        logic [10:0] t;
        case (tmode)
            TM_READ, TM_NEXT: begin
                t = {3'b000, bufm[bptr]};
                bptr++;
                if (bptr == 0) begin
                    fetch_sector();
                    sptr++;
                end
            end
            TM_SPARE: begin
                t = {3'b000, bufs[bptr]};
                bptr++;
                if (bptr == 0) tmode = TM_DONE;
            end
            TM_POS: begin
                if (rptr == 0) t = {3'b000, sptr[15:8]};
                else if (rptr == 1) t = {3'b000, sptr[7:0]};
                else if (rptr == 2) t = {3'b000, bptr};
                else t = EOT_FRAME;
                next_report();
            end
            TM_GEOM: begin
                if (rptr < 12) begin
                    t = {3'b000, geo_bytes[rptr]};
                    next_report();
                end else t = EOT_FRAME;
            end
            TM_CAP: begin
                if (rptr == 0) t = {3'b000, 8'(SECTORS >> 8)};
                else if (rptr == 1) t = {3'b000, 8'(SECTORS)};
                else t = EOT_FRAME;
                next_report();
            end
            default: t = EOT_FRAME;
        endcase
        if (t == EOT_FRAME) ls = LS_TALK;
        return t;
    endfunction

    function automatic void listener_byte(input logic [10:0] f);
        logic [7:0] b;
        b = f[7:0];
        case (lmode)
            LM_WRITE, LM_BUF, LM_PARTIAL: begin
                bufm[bptr] = b;
                bptr++;
                if (bptr == 0) begin
                    commit_sector();
                    sptr++;
                    if (pwrite) fetch_sector();
                end else if (f[9]) begin
                    commit_sector();
                    if (!pwrite) sptr++;
                end
            end
            LM_SPARE: begin
                bufs[bptr] = b;
                bptr++;
            end
            LM_PTR: bptr = b;
            LM_SEEK: begin
                if (seek_hi) begin
                    pend = {pend[15:8], b};
                    if (pend < SEC_LIMIT) begin
                        sptr = pend;
                        stat = 0;
                    end else stat = STATUS_SEEK_ERR;
                    seek_hi = 0;
                end else begin
                    pend = {b, pend[7:0]};
                    seek_hi = 1;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void command(input logic [7:0] n);
        logic [4:0] low;
        low = n[4:0];
        case (n[7:5])
            GRP_MISC: begin
                if (n == CMD_SDC) begin
                    if (ls[7]) clear_position();
                end else if (n == CMD_DCL) clear_position();
            end
            GRP_LISTEN: begin
                if (low == ADR_UNL) begin
                    if (!ls[6]) ls = LS_IDLE;
                end else if (low == own_addr[4:0]) ls = LS_LISTEN;
            end
            GRP_TALK: begin
                if (low == own_addr[4:0]) ls = LS_TALK;
                else if (ls[6]) ls = LS_IDLE;
            end
            GRP_IFC: begin
                if (low == IFC_IFC) ls = LS_IDLE;
                else if (low == IFC_AAU) own_addr = AUTO_ADDR;
            end
            GRP_LMODE: begin
                if (ls[7:6] == 2'b10) begin
                    lmode = low;
                    case (low)
                        LM_SPARE: pwrite = 0;
                        LM_BUF: begin
                            bptr = 0;
                            pwrite = 0;
                        end
                        LM_SEEK: begin
                            pwrite = 0;
                            seek_hi = 0;
                        end
                        LM_FORMAT: begin
                            stat = 0;
                            for (int i = 0; i < STORE_BYTES; i++) sector_mem[i] = 8'hFF;
                        end
                        LM_PARTIAL: begin
                            pwrite = 1;
                            fetch_sector();
                        end
                        LM_REWIND: clear_position();
                        LM_FLUSH: begin
                            commit_sector();
                            if (!pwrite) sptr++;
                        end
                        LM_COPY: begin
                            bptr = 0;
                            bufs = bufm;
                        end
                        LM_XCHG: swap_bufs();
                        default: ;
                    endcase
                end
            end
            GRP_TMODE: begin
                if (ls[6]) begin
                    tmode = low;
                    rptr = 0;
                    if (low == TM_READ) pwrite = 0;
                    else if (low == TM_NEXT) begin
                        fetch_sector();
                        bptr = 0;
                        pwrite = 0;
                        sptr++;
                    end else if (low == TM_XCHG) swap_bufs();
                end
            end
            default: ;
        endcase
    endfunction

    function automatic logic [10:0] ready_reply(input logic [10:0] f);
        logic [7:0]  n;
        logic [10:0] r;
        n = f[7:0];
        r = f;
        if (n <= 127) begin
            if (ls[6]) begin
                if (n == RDY_NRE) ls &= LS_SDA_MASK;
                else if (n == RDY_SDA) begin
                    ls = LS_TALK_DATA;
                    r = talker_byte();
                end else if (n == RDY_SST) begin
                    r = {3'b000, stat};
                    stat &= STATUS_MASK;
                    ls = LS_TALK_BYTE;
                end else if (n == RDY_SDI) begin
                    r = {3'b000, ident_chars[0]};
                    id_ptr = 2;
                    ls = LS_TALK_ID;
                end else if (n == RDY_SAI) begin
                    r = {3'b000, ACC_ID};
                    ls = LS_TALK_BYTE;
                end
            end
        end else if (n < RDY_AAD_END) begin
            if (!own_addr[7]) begin
                own_addr = n;
                r = f + 11'd1;
            end
        end
        return r;
    endfunction

    function automatic logic [10:0] data_reply(input logic [10:0] f);
        logic [10:0] r;
        logic [7:0]  c;
        logic [3:0]  k;
        r = f;
        if (!ls[7]) return f;
        if (!ls[6]) begin
            listener_byte(f);
            return f;
        end
        if (!ls[1]) begin
            ls = LS_TALK;
            return EOT_FRAME;
        end
        if (!ls[0]) return talker_byte();
        if (id_ptr != 0) begin
            k = id_ptr - 4'd1;
            c = ident_chars[k[2:0]];
            if (c == CHAR_CR) id_ptr = 0;
            else begin
                id_ptr++;
                r = {3'b000, c};
            end
        end
        if (id_ptr == 0) begin
            r = EOT_FRAME;
            ls = LS_TALK;
        end
        return r;
    endfunction

    function automatic logic [10:0] drive_response(input logic [10:0] f);
        if (!f[10]) return data_reply(f);
        if (f[10:8] == CLS_CMD) command(f[7:0]);
        else if (f[10:8] == CLS_RDY) return ready_reply(f);
        return f;
    endfunction

    function automatic logic [10:0] cmd_f(input logic [2:0] grp, input logic [4:0] low);
        return {CLS_CMD, grp, low};
    endfunction

    function automatic logic [10:0] rdy_f(input logic [7:0] n);
        return {CLS_RDY, n};
    endfunction

    function automatic logic [10:0] dat_f(input logic [7:0] b, input bit last);
        return {1'b0, last, 1'b0, b};
    endfunction

    // Offer one item, hold until accepted, record the expected frame
    task automatic send_item(input logic [10:0] f);
        int gap;
        s_valid <= 1'b1;
        s_frame_in <= f;
        do @(posedge aclk); while (!s_ready);
        exp_frames.push_back(drive_response(f));
        n_sent++;
        if (burst_left > 0) burst_left--;
        else begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic listen_on();
        send_item(cmd_f(GRP_LISTEN, own_addr[4:0]));
    endtask

    task automatic talk_on();
        send_item(cmd_f(GRP_TALK, own_addr[4:0]));
    endtask

    task automatic unlisten();
        send_item(cmd_f(GRP_LISTEN, ADR_UNL));
    endtask

    task automatic untalk();
        send_item(cmd_f(GRP_TALK, ADR_UNL));
    endtask

    // Receiver: long hold on request, otherwise a rotating stall pattern
    always @(posedge aclk) begin
        stall_phase <= stall_phase + 1;
        if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_ready <= 1'b0;
        end else if (hold_req) begin
            hold_req <= 1'b0;
            hold_cnt <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            case ((stall_phase >> 7) % 3)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 1) == 0);
                default: m_ready <= ((stall_phase & 3) == 0);
            endcase
        end
    end

    // Compare each output frame with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (exp_frames.size() == 0) begin
                $error("unexpected frame_out %h", m_frame_out);
                err_cnt++;
            end else begin
                logic [10:0] want;
                want = exp_frames.pop_front();
                if (m_frame_out !== want) begin
                    $error("frame_out: expected %h, got %h", want, m_frame_out);
                    err_cnt++;
                end
            end
        end
    end

    // Abort when no item moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cnt <= 0;
        else idle_cnt <= idle_cnt + 1;
        if (idle_cnt == IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic test_addressing();
        send_item(cmd_f(GRP_IFC, IFC_AAU));
        send_item(rdy_f(8'h80 + 8'd5));
        send_item(rdy_f(8'h80 + 8'd9));
        send_item(rdy_f(RDY_AAD_END));
        send_item({3'b110, 8'hA5});
        send_item({3'b111, 8'h5A});
        send_item(cmd_f(GRP_IFC, IFC_IFC));
        send_item(cmd_f(GRP_MISC, CMD_DCL[4:0]));
    endtask

    task automatic test_write_read();
        listen_on();
        send_item(cmd_f(GRP_LMODE, LM_WRITE));
        send_item(dat_f(8'h00, 0));
        send_item(dat_f(8'hFF, 1));
        send_item(cmd_f(GRP_LMODE, LM_REWIND));
        unlisten();
        talk_on();
        send_item(cmd_f(GRP_TMODE, TM_NEXT));
        send_item(rdy_f(RDY_SDA));
        send_item(dat_f(8'h00, 0));
        send_item(dat_f(8'h00, 0));
        untalk();
    endtask

    task automatic test_capacity_edges();
        listen_on();
        send_item(cmd_f(GRP_LMODE, LM_SEEK));
        send_item(dat_f(8'hFF, 0));
        send_item(dat_f(8'hFF, 0));
        send_item(dat_f(8'h09, 0));
        send_item(dat_f(8'hFF, 0));
        send_item(cmd_f(GRP_LMODE, LM_FLUSH));
        send_item(cmd_f(GRP_LMODE, LM_FLUSH));
        unlisten();
        talk_on();
        send_item(rdy_f(RDY_SST));
        send_item(dat_f(8'h00, 0));
        send_item(cmd_f(GRP_TMODE, TM_NEXT));
        send_item(rdy_f(RDY_SDA));
        send_item(cmd_f(GRP_TMODE, TM_POS));
        send_item(rdy_f(RDY_SDA));
        send_item(dat_f(8'h00, 0));
        send_item(dat_f(8'h00, 0));
        send_item(dat_f(8'h00, 0));
        untalk();
    endtask

    task automatic test_reports_and_id();
        talk_on();
        send_item(cmd_f(GRP_TMODE, TM_CAP));
        send_item(rdy_f(RDY_SDA));
        send_item(dat_f(8'h00, 0));
        send_item(dat_f(8'h00, 0));
        send_item(rdy_f(RDY_SDI));
        for (int i = 0; i < 8; i++) send_item(dat_f(8'h00, 0));
        send_item(rdy_f(RDY_SAI));
        send_item(dat_f(8'h00, 0));
        send_item(rdy_f(RDY_NRE));
        send_item(dat_f(8'h00, 0));
        untalk();
    endtask

    task automatic test_format();
        listen_on();
        send_item(cmd_f(GRP_LMODE, LM_COPY));
        send_item(cmd_f(GRP_LMODE, LM_XCHG));
        send_item(cmd_f(GRP_LMODE, LM_FORMAT));
        unlisten();
    endtask

    task automatic rand_listen();
        logic [4:0] mode;
        int         n;
        listen_on();
        do mode = 5'($urandom_range(0, 31)); while (mode == LM_FORMAT);
        if ($urandom_range(0, 1) == 0) mode = 5'($urandom_range(0, 10));
        if (mode == LM_FORMAT) mode = LM_WRITE;
        send_item(cmd_f(GRP_LMODE, mode));
        if (mode == LM_SEEK) begin
            case ($urandom_range(0, 3))
                0: send_item(dat_f(8'hFF, 1'($urandom_range(0, 1))));
                1: send_item(dat_f(8'h09, 1'($urandom_range(0, 1))));
                default: send_item(dat_f(8'($urandom_range(0, 10)),
                                         1'($urandom_range(0, 1))));
            endcase
            send_item(dat_f(8'($urandom), 1'($urandom_range(0, 1))));
        end else begin
            n = ($urandom_range(0, 12) == 0) ? $urandom_range(250, 300)
                                              : $urandom_range(1, 8);
            for (int i = 0; i < n; i++)
                send_item({1'b0, ($urandom_range(0, 15) == 0), 9'($urandom)});
        end
        if ($urandom_range(0, 9) < 7) unlisten();
    endtask

    task automatic rand_talk();
        int n;
        talk_on();
        send_item(cmd_f(GRP_TMODE, ($urandom_range(0, 1) == 0) ? 5'($urandom_range(0, 7))
                                                                : 5'($urandom)));
        send_item(rdy_f(RDY_SDA));
        n = ($urandom_range(0, 12) == 0) ? $urandom_range(250, 300) : $urandom_range(1, 16);
        for (int i = 0; i < n; i++) send_item({1'b0, 10'($urandom)});
        untalk();
    endtask

    task automatic rand_session();
        int         r;
        logic [10:0] f;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            repeat ($urandom_range(1, 4)) begin
                f = 11'($urandom);
                // keep the erase pass out of the random part
                if (f[10:8] == CLS_CMD && f[7:5] == GRP_LMODE && f[4:0] == LM_FORMAT)
                    f[0] = 1'b0;
                send_item(f);
            end
        end else if (r < 42) rand_listen();
        else if (r < 75) rand_talk();
        else if (r < 85) begin
            talk_on();
            case ($urandom_range(0, 3))
                0: send_item(rdy_f(RDY_SST));
                1: send_item(rdy_f(RDY_SDI));
                2: send_item(rdy_f(RDY_SAI));
                default: send_item(rdy_f(RDY_NRE));
            endcase
            repeat ($urandom_range(1, 10)) send_item({1'b0, 10'($urandom)});
        end else if (r < 95) begin
            case ($urandom_range(0, 4))
                0: send_item(cmd_f(GRP_IFC, IFC_IFC));
                1: send_item(cmd_f(GRP_IFC, IFC_AAU));
                2: send_item(rdy_f(8'h80 + 8'($urandom_range(0, 31))));
                3: send_item(cmd_f(GRP_MISC, CMD_DCL[4:0]));
                default: send_item(cmd_f(GRP_MISC, CMD_SDC[4:0]));
            endcase
        end else send_item(rdy_f(8'($urandom)));
    endtask

    task automatic test_random();
        int goal;
        bit held;
        goal = n_sent + RAND_ITEMS;
        held = 0;
        while (n_sent < goal) begin
            // stall the receiver once while items keep coming
            if (!held && n_sent > goal - RAND_ITEMS / 2) begin
                held = 1;
                hold_req = 1'b1;
            end
            rand_session();
        end
    endtask

    initial begin
        ls = LS_IDLE; own_addr = 0; id_ptr = 0; stat = 0;
        lmode = 0; tmode = 0; bptr = 0; rptr = 0;
        sptr = 0; pend = 0; seek_hi = 0; pwrite = 0;
        for (int i = 0; i < 256; i++) begin
            bufm[i] = 0;
            bufs[i] = 0;
        end
        for (int i = 0; i < STORE_BYTES; i++) sector_mem[i] = 8'hFF;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_addressing();
        test_write_read();
        test_capacity_edges();
        test_reports_and_id();
        test_format();
        test_random();

        s_valid <= 1'b0;
        while (exp_frames.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (err_cnt == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: serial_loop_disc_drive.f
sv/sld_pkg.sv
sv/sld_core.sv
sv/serial_loop_disc_drive.sv
tb/sv/tb_serial_loop_disc_drive.sv
